// ----- rtl/core/rnsm_pkg.sv -----
`timescale 1ns / 1ps

package rnsm_pkg;

    localparam logic [23:0] GLYPH_POINT_FIRST  = 24'h100000;
    localparam logic [23:0] GLYPH_POINT_SECOND = 24'h010000;
    localparam logic [23:0] GLYPH_MINUS_HUND   = 24'h000002;
    localparam logic [23:0] GLYPH_MINUS_TENS   = 24'h000020;
    localparam logic [23:0] GLYPH_MINUS_ONES   = 24'h000200;
    localparam logic [23:0] GLYPH_DASHES       = 24'h000222;

    localparam logic [1:0] CNT_BLANK = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    typedef struct packed {
        logic [8:0]  sq;
        logic [12:0] cu;
    } rad_pow_t;

    typedef struct packed {
        logic [3:0]  quo;
        logic [11:0] rem;
    } div_res_t;

    typedef struct packed {
        logic [1:0]  cnt;
        logic        ovf;
        logic        minus;
        logic        p1;
        logic        p2;
        logic [11:0] mag;
        logic [4:0]  rad;
        logic [8:0]  rad_sq;
    } st1_t;

    typedef struct packed {
        logic [1:0] cnt;
        logic       ovf;
        logic       minus;
        logic       p1;
        logic       p2;
        logic [3:0] hund;
        logic [7:0] rem;
        logic [4:0] rad;
    } st2_t;

    typedef struct packed {
        logic [1:0] cnt;
        logic       ovf;
        logic       minus;
        logic       p1;
        logic       p2;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } st3_t;

    function automatic rad_pow_t rad_pow(input logic [4:0] rad);
        rad_pow_t res;
        unique case (rad)
            5'd2:    res = '{sq: 9'd4,   cu: 13'd8};
            5'd3:    res = '{sq: 9'd9,   cu: 13'd27};
            5'd4:    res = '{sq: 9'd16,  cu: 13'd64};
            5'd5:    res = '{sq: 9'd25,  cu: 13'd125};
            5'd6:    res = '{sq: 9'd36,  cu: 13'd216};
            5'd7:    res = '{sq: 9'd49,  cu: 13'd343};
            5'd8:    res = '{sq: 9'd64,  cu: 13'd512};
            5'd9:    res = '{sq: 9'd81,  cu: 13'd729};
            5'd10:   res = '{sq: 9'd100, cu: 13'd1000};
            5'd11:   res = '{sq: 9'd121, cu: 13'd1331};
            5'd12:   res = '{sq: 9'd144, cu: 13'd1728};
            5'd13:   res = '{sq: 9'd169, cu: 13'd2197};
            5'd14:   res = '{sq: 9'd196, cu: 13'd2744};
            5'd15:   res = '{sq: 9'd225, cu: 13'd3375};
            5'd16:   res = '{sq: 9'd256, cu: 13'd4096};
            default: res = '{sq: 9'd0,   cu: 13'd0};
        endcase
        return res;
    endfunction

    // restoring division, four quotient bits
    function automatic div_res_t div_digit(input logic [11:0] dividend,
                                           input logic [8:0] divisor);
        logic [12:0] rem;
        logic [12:0] sub;
        div_res_t    res;
        rem = {1'b0, dividend};
        res.quo = 4'd0;
        for (int k = 3; k >= 0; k--) begin
            sub = {4'd0, divisor} << k;
            if (rem >= sub) begin
                rem = rem - sub;
                res.quo[k] = 1'b1;
            end
        end
        res.rem = rem[11:0];
        return res;
    endfunction

    function automatic logic [23:0] ones_glyph(input logic [3:0] d);
        logic [23:0] g;
        unique case (d)
            4'h0: g = 24'h00FC00;
            4'h1: g = 24'h003000;
            4'h2: g = 24'h00DA00;
            4'h3: g = 24'h007A00;
            4'h4: g = 24'h003600;
            4'h5: g = 24'h006E00;
            4'h6: g = 24'h00EE00;
            4'h7: g = 24'h003800;
            4'h8: g = 24'h00FE00;
            4'h9: g = 24'h007E00;
            4'hA: g = 24'h00BE00;
            4'hB: g = 24'h00E600;
            4'hC: g = 24'h00CC00;
            4'hD: g = 24'h00F200;
            4'hE: g = 24'h00CE00;
            4'hF: g = 24'h008E00;
        endcase
        return g;
    endfunction

    function automatic logic [23:0] tens_glyph(input logic [3:0] d);
        logic [23:0] g;
        unique case (d)
            4'h0: g = 24'h0E01C0;
            4'h1: g = 24'h020100;
            4'h2: g = 24'h0C01A0;
            4'h3: g = 24'h0601A0;
            4'h4: g = 24'h020160;
            4'h5: g = 24'h0600E0;
            4'h6: g = 24'h0E00E0;
            4'h7: g = 24'h020180;
            4'h8: g = 24'h0E01E0;
            4'h9: g = 24'h0601E0;
            4'hA: g = 24'h0A01E0;
            4'hB: g = 24'h0E0060;
            4'hC: g = 24'h0C00C0;
            4'hD: g = 24'h0E0120;
            4'hE: g = 24'h0C00E0;
            4'hF: g = 24'h0800E0;
        endcase
        return g;
    endfunction

    function automatic logic [23:0] hund_glyph(input logic [3:0] d);
        logic [23:0] g;
        unique case (d)
            4'h0: g = 24'hE0001C;
            4'h1: g = 24'h200010;
            4'h2: g = 24'hC0001A;
            4'h3: g = 24'h60001A;
            4'h4: g = 24'h200016;
            4'h5: g = 24'h60000E;
            4'h6: g = 24'hE0000E;
            4'h7: g = 24'h200018;
            4'h8: g = 24'hE0001E;
            4'h9: g = 24'h60001E;
            4'hA: g = 24'hA0001E;
            4'hB: g = 24'hE00006;
            4'hC: g = 24'hC0000C;
            4'hD: g = 24'hE00012;
            4'hE: g = 24'hC0000E;
            4'hF: g = 24'h80000E;
        endcase
        return g;
    endfunction

endpackage

// ----- rtl/core/rnsm_glyph.sv -----
`timescale 1ns / 1ps

module rnsm_glyph import rnsm_pkg::*; (
    input  st3_t        st,
    output logic [23:0] mask
);

    logic [23:0] digits;
    logic [23:0] points;

    always_comb begin
        points = (st.p1 ? GLYPH_POINT_FIRST : 24'd0) | (st.p2 ? GLYPH_POINT_SECOND : 24'd0);
        unique case (st.cnt)
            CNT_ONE:   digits = ones_glyph(st.ones);
            CNT_TWO:   digits = (st.minus ? GLYPH_MINUS_TENS : tens_glyph(st.tens))
                                | ones_glyph(st.ones);
            CNT_THREE: digits = (st.minus ? GLYPH_MINUS_HUND : hund_glyph(st.hund))
                                | tens_glyph(st.tens) | ones_glyph(st.ones);
            default:   digits = 24'd0;
        endcase
        unique case (st.cnt)
            CNT_BLANK: mask = 24'd0;
            CNT_ONE:   mask = st.ovf ? GLYPH_MINUS_ONES : (digits | points);
            CNT_TWO:   mask = st.ovf ? (GLYPH_MINUS_TENS | GLYPH_MINUS_ONES) : (digits | points);
            CNT_THREE: mask = st.ovf ? GLYPH_DASHES : (digits | points);
        endcase
    end

endmodule

// ----- rtl/core/radix_number_to_segment_mask.sv -----
`timescale 1ns / 1ps
// channel | ports                                                   | accepted when
// input   | s_digit_count s_radix s_number s_point_first/second     | s_valid && s_ready
//         | s_sign_shown                                            |
// result  | m_segments                                              | m_valid && m_ready
//
// Four registered stages; one item per cycle sustained while m_ready is held high.
// Stage 1 forms the magnitude and overflow test, stage 2 the top digit (four
// compare-subtract steps by radix squared), stage 3 the two low digits, stage 4
// the glyph OR into the output register.
// aresetn clears the stage valid bits only. A stalled output holds; empty stages
// still take items, so s_ready drops only when all four stages are full.

module radix_number_to_segment_mask import rnsm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_digit_count,
    input  logic [4:0]  s_radix,
    input  logic signed [15:0] s_number,
    input  logic        s_point_first,
    input  logic        s_point_second,
    input  logic        s_sign_shown,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_segments
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        rdy1, rdy2, rdy3, rdy4;
    st1_t        st1_reg, st1_next;
    st2_t        st2_reg, st2_next;
    st3_t        st3_reg, st3_next;
    logic [23:0] seg_reg, seg_next;

    logic        neg;
    logic        minus;
    logic        bad_rad;
    logic [16:0] mag;
    rad_pow_t    pw;
    div_res_t    dh;
    div_res_t    dt;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_comb begin
        neg     = s_number[15];
        minus   = neg && s_sign_shown;
        mag     = neg ? (17'h10000 - {1'b0, s_number}) : {1'b0, s_number};
        bad_rad = (s_radix < 5'd2) || (s_radix > 5'd16);
        pw      = rad_pow(s_radix);
        st1_next.cnt    = s_digit_count;
        st1_next.minus  = minus;
        st1_next.p1     = s_point_first;
        st1_next.p2     = s_point_second;
        st1_next.mag    = mag[11:0];
        st1_next.rad    = s_radix;
        st1_next.rad_sq = pw.sq;
        unique case (s_digit_count)
            CNT_ONE:   st1_next.ovf = bad_rad || minus || (mag >= {12'd0, s_radix});
            CNT_TWO:   st1_next.ovf = bad_rad || (mag >= {8'd0, pw.sq})
                                      || (minus && (mag >= {12'd0, s_radix}));
            CNT_THREE: st1_next.ovf = bad_rad || (mag >= {4'd0, pw.cu})
                                      || (minus && (mag >= {8'd0, pw.sq}));
            default:   st1_next.ovf = 1'b0;
        endcase
    end

    always_comb begin
        dh = div_digit(st1_reg.mag, st1_reg.rad_sq);
        st2_next.cnt   = st1_reg.cnt;
        st2_next.ovf   = st1_reg.ovf;
        st2_next.minus = st1_reg.minus;
        st2_next.p1    = st1_reg.p1;
        st2_next.p2    = st1_reg.p2;
        st2_next.hund  = dh.quo;
        st2_next.rem   = dh.rem[7:0];
        st2_next.rad   = st1_reg.rad;
    end

    always_comb begin
        dt = div_digit({4'd0, st2_reg.rem}, {4'd0, st2_reg.rad});
        st3_next.cnt   = st2_reg.cnt;
        st3_next.ovf   = st2_reg.ovf;
        st3_next.minus = st2_reg.minus;
        st3_next.p1    = st2_reg.p1;
        st3_next.p2    = st2_reg.p2;
        st3_next.hund  = st2_reg.hund;
        st3_next.tens  = dt.quo;
        st3_next.ones  = dt.rem[3:0];
    end

    rnsm_glyph u_glyph (
        .st   (st3_reg),
        .mask (seg_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && rdy1) st1_reg <= st1_next;
        if (v1_reg && rdy2)  st2_reg <= st2_next;
        if (v2_reg && rdy3)  st3_reg <= st3_next;
        if (v3_reg && rdy4)  seg_reg <= seg_next;
    end

    assign m_valid    = v4_reg;
    assign m_segments = seg_reg;

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("output empty but input not ready");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted item lost in first stage");

    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && v1_reg && v2_reg && v3_reg) |-> !s_ready)
        else $error("input ready while pipeline full and stalled");

    a_stall_holds_s3: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !rdy4) |=> (v3_reg && $stable(st3_reg)))
        else $error("stalled stage three changed");

endmodule
